// ===== rtl/rlh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the RGB/luma histogram unit.
// No dependencies.
package rlh_pkg;

    localparam int CNT_W      = 24;
    localparam int BIN_N      = 256;
    localparam int BIN_W      = 8;
    localparam int CH_N       = 4;
    localparam int SWEEP_W    = 9;
    localparam int STRIDE_W   = 13;
    localparam int WIDTH_W    = 16;
    localparam int PHASE_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    localparam logic [STRIDE_W-1:0] STRIDE_MAX = STRIDE_W'(4096);
    localparam logic [7:0]          CLIP_MUL   = 8'd200;
    localparam logic [CNT_W-1:0]    CNT_MAX    = {CNT_W{1'b1}};

    localparam logic [16:0] LUMA_R   = 17'd13933;
    localparam logic [16:0] LUMA_G   = 17'd46871;
    localparam logic [16:0] LUMA_B   = 17'd4732;
    localparam logic [24:0] LUMA_RND = 25'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef enum logic [1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // channel order: red, green, blue, luma
    typedef struct packed {
        t_op                         op;
        logic                        keep;
        logic                        last;
        logic [CH_N-1:0][BIN_W-1:0]  addr;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_stat;

    typedef struct packed {
        logic                        kind;
        logic [CH_N-1:0][CNT_W-1:0]  count;
        logic [CNT_W-1:0]            peak;
        logic                        shadow;
        logic                        highlight;
        logic [CNT_W-1:0]            samples;
    } t_result;

    function automatic logic [BIN_W-1:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        logic [24:0] s;
        logic [8:0]  y;
        s = 25'(LUMA_R) * 25'(r) + 25'(LUMA_G) * 25'(g) + 25'(LUMA_B) * 25'(b) + LUMA_RND;
        y = s[24:16];
        return (y > 9'd255) ? 8'd255 : y[7:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] max2(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/rlh_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests, tracks raster position and sampling phase,
// computes luma and queues work for the back end. Depends on rlh_pkg.
module rlh_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic                          i_last_pixel,
    input  logic [7:0]                    i_bin_index,
    input  logic                          i_cfg_we,
    input  logic [rlh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rlh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_q_full,
    input  rlh_pkg::t_stat                i_stat,
    output logic                          o_push,
    output rlh_pkg::t_cmd                 o_cmd
);
    import rlh_pkg::*;

    logic [STRIDE_W-1:0] r_stride;
    logic [WIDTH_W-1:0]  r_width;
    logic [WIDTH_W-1:0]  r_col_pos, n_col_pos;
    logic [PHASE_W-1:0]  r_col_ph, n_col_ph;
    logic [PHASE_W-1:0]  r_row_ph, n_row_ph;

    logic [STRIDE_W-1:0] eff_s;
    logic [WIDTH_W-1:0]  eff_w;
    logic                accept, keep;
    t_func               func;

    assign func    = t_func'(i_func);
    assign o_stall = i_q_full || i_stat.init_busy;
    assign accept  = i_valid && !o_stall;
    assign keep    = (r_col_ph == '0) && (r_row_ph == '0);

    always_comb begin
        eff_s = r_stride;
        if (r_stride == '0) begin
            eff_s = STRIDE_W'(1);
        end else if (r_stride > STRIDE_MAX) begin
            eff_s = STRIDE_MAX;
        end
        eff_w = (r_width == '0) ? WIDTH_W'(1) : r_width;
    end

    always_comb begin
        n_col_pos = r_col_pos;
        n_col_ph  = r_col_ph;
        n_row_ph  = r_row_ph;
        if (accept && func == FUNC_PIXEL) begin
            if ({1'b0, r_col_pos} + 17'd1 >= {1'b0, eff_w}) begin
                n_col_pos = '0;
                n_col_ph  = '0;
                n_row_ph  = ({1'b0, r_row_ph} + 13'd1 >= eff_s) ? '0 : r_row_ph + 1'b1;
            end else begin
                n_col_pos = r_col_pos + 1'b1;
                n_col_ph  = ({1'b0, r_col_ph} + 13'd1 >= eff_s) ? '0 : r_col_ph + 1'b1;
            end
            if (i_last_pixel) begin
                n_col_pos = '0;
                n_col_ph  = '0;
                n_row_ph  = '0;
            end
        end else if (accept && func == FUNC_CLEAR) begin
            n_col_pos = '0;
            n_col_ph  = '0;
            n_row_ph  = '0;
        end
    end

    always_comb begin
        o_cmd.keep = keep;
        o_cmd.last = i_last_pixel;
        o_push     = 1'b0;
        o_cmd.op   = OP_PIXEL;
        o_cmd.addr = {luma_of(i_red, i_green, i_blue), i_blue, i_green, i_red};
        case (func)
            FUNC_PIXEL: begin
                o_push = accept && (keep || i_last_pixel);
            end
            FUNC_READ: begin
                o_push     = accept;
                o_cmd.op   = OP_READ;
                o_cmd.addr = {CH_N{i_bin_index}};
            end
            FUNC_CLEAR: begin
                o_push   = accept;
                o_cmd.op = OP_CLEAR;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride  <= STRIDE_W'(1);
            r_width   <= WIDTH_W'(1);
            r_col_pos <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
        end else begin
            r_col_pos <= n_col_pos;
            r_col_ph  <= n_col_ph;
            r_row_ph  <= n_row_ph;
            if (i_cfg_we && i_cfg_index == CFG_STRIDE) begin
                r_stride <= i_cfg_data[STRIDE_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_WIDTH) begin
                r_width <= i_cfg_data[WIDTH_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/rlh_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on rlh_pkg.
module rlh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rlh_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output rlh_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import rlh_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_fill;

    assign o_full  = (r_fill == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

endmodule

// ===== rtl/rlh_back.sv =====
`timescale 1ns / 1ps
// Back end: bin memories, read-modify-write of counts, readback, clear sweep and
// summary sweep, and the result register. Depends on rlh_pkg.
module rlh_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  rlh_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output rlh_pkg::t_stat   o_stat,
    output logic             o_valid,
    input  logic             i_stall,
    output rlh_pkg::t_result o_res
);
    import rlh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX_WR,
        ST_RD_DATA,
        ST_CLR,
        ST_FIN,
        ST_FLAG,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic               r_init;
    t_cmd               r_cmd;
    logic [SWEEP_W-1:0] r_cnt;
    logic               r_fin_vld;
    logic [BIN_W-1:0]   r_fin_idx;
    logic [CNT_W-1:0]   r_top [CH_N];
    logic [CNT_W-1:0]   n_top [CH_N];
    logic [CNT_W-1:0]   r_sh, r_hi;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_peak;
    logic               r_shadow, r_highlight;
    t_result            r_res;
    t_result            r_out;
    logic               r_ovalid;

    logic [CNT_W-1:0]   r_mem  [CH_N][BIN_N];
    logic [CNT_W-1:0]   r_rdat [CH_N];
    logic [BIN_W-1:0]   rd_addr [CH_N];
    logic [BIN_W-1:0]   wr_addr;
    logic               we, out_free;
    logic [CNT_W-1:0]   mx_rgb, mx_all;
    logic [CH_N-1:0]    gt;
    logic [31:0]        sh_prod, hi_prod;
    logic [CNT_W-1:0]   peak_v;

    assign o_stat.init_busy = r_init;
    assign o_valid  = r_ovalid;
    assign o_res    = r_out;
    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    assign we      = (r_state == ST_PIX_WR) || (r_state == ST_CLR);
    assign wr_addr = r_cnt[BIN_W-1:0];

    for (genvar ch = 0; ch < CH_N; ch++) begin : g_mem
        always_comb begin
            case (r_state)
                ST_IDLE: rd_addr[ch] = i_cmd.addr[ch];
                ST_FIN:  rd_addr[ch] = r_cnt[BIN_W-1:0];
                default: rd_addr[ch] = r_cmd.addr[ch];
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                if (r_state == ST_CLR) begin
                    r_mem[ch][wr_addr] <= '0;
                end else begin
                    r_mem[ch][r_cmd.addr[ch]] <= sat_inc(r_rdat[ch]);
                end
            end
            r_rdat[ch] <= r_mem[ch][rd_addr[ch]];
        end
    end

    // insert the bin maximum into the sorted top four
    assign mx_rgb = max2(max2(r_rdat[0], r_rdat[1]), r_rdat[2]);
    assign mx_all = max2(mx_rgb, r_rdat[3]);

    always_comb begin
        for (int k = 0; k < CH_N; k++) begin
            gt[k] = mx_all > r_top[k];
        end
        for (int k = 0; k < CH_N; k++) begin
            if (!gt[k]) begin
                n_top[k] = r_top[k];
            end else if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
                n_top[k] = r_top[(k > 0) ? k - 1 : 0];
            end else begin
                n_top[k] = mx_all;
            end
        end
    end

    assign sh_prod = 32'(r_sh) * 32'(CLIP_MUL);
    assign hi_prod = 32'(r_hi) * 32'(CLIP_MUL);
    assign peak_v  = (r_top[CH_N-1] == '0) ? CNT_W'(1) : r_top[CH_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_fin_vld   <= 1'b0;
            r_total     <= '0;
            r_peak      <= '0;
            r_shadow    <= 1'b0;
            r_highlight <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // load a new result when the slot is free, else drop an accepted one
            if (r_state == ST_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.op)
                            OP_PIXEL: begin
                                if (i_cmd.keep) begin
                                    r_state <= ST_PIX_WR;
                                end else begin
                                    r_state   <= ST_FIN;
                                    r_cnt     <= '0;
                                    r_fin_vld <= 1'b0;
                                    for (int k = 0; k < CH_N; k++) r_top[k] <= '0;
                                end
                            end
                            OP_READ: r_state <= ST_RD_DATA;
                            OP_CLEAR: begin
                                r_state     <= ST_CLR;
                                r_cnt       <= '0;
                                r_total     <= '0;
                                r_peak      <= '0;
                                r_shadow    <= 1'b0;
                                r_highlight <= 1'b0;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_PIX_WR: begin
                    r_total <= sat_inc(r_total);
                    if (r_cmd.last) begin
                        r_state   <= ST_FIN;
                        r_cnt     <= '0;
                        r_fin_vld <= 1'b0;
                        for (int k = 0; k < CH_N; k++) r_top[k] <= '0;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD_DATA: begin
                    r_res.kind      <= KIND_READ;
                    for (int k = 0; k < CH_N; k++) r_res.count[k] <= r_rdat[k];
                    r_res.peak      <= r_peak;
                    r_res.shadow    <= r_shadow;
                    r_res.highlight <= r_highlight;
                    r_res.samples   <= r_total;
                    r_state         <= ST_EMIT;
                end
                ST_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[BIN_W-1:0] == BIN_W'(BIN_N - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    r_cnt     <= r_cnt + 1'b1;
                    r_fin_vld <= !r_cnt[SWEEP_W-1];
                    r_fin_idx <= r_cnt[BIN_W-1:0];
                    if (r_fin_vld) begin
                        for (int k = 0; k < CH_N; k++) r_top[k] <= n_top[k];
                        if (r_fin_idx == '0) begin
                            r_sh <= mx_rgb;
                        end
                        if (r_fin_idx == BIN_W'(BIN_N - 1)) begin
                            r_hi <= mx_rgb;
                        end
                    end
                    if (r_cnt[SWEEP_W-1]) begin
                        r_state <= ST_FLAG;
                    end
                end
                ST_FLAG: begin
                    r_res.kind <= KIND_SUMMARY;
                    for (int k = 0; k < CH_N; k++) r_res.count[k] <= '0;
                    r_res.samples <= r_total;
                    if (r_total == '0) begin
                        r_peak          <= '0;
                        r_shadow        <= 1'b0;
                        r_highlight     <= 1'b0;
                        r_res.peak      <= '0;
                        r_res.shadow    <= 1'b0;
                        r_res.highlight <= 1'b0;
                    end else begin
                        r_peak          <= peak_v;
                        r_shadow        <= sh_prod > 32'(r_total);
                        r_highlight     <= hi_prod > 32'(r_total);
                        r_res.peak      <= peak_v;
                        r_res.shadow    <= sh_prod > 32'(r_total);
                        r_res.highlight <= hi_prod > 32'(r_total);
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/rgb_luma_histogram_stats_unit.sv =====
`timescale 1ns / 1ps
// RGB and luma histogram unit: a kept pixel occupies the back end for a
// read-modify-write of the bin memories; a skipped pixel is queued only if last.
// A readback goes via ST_RD_DATA and ST_EMIT after leaving the queue.
// Summary and clear each sweep the 256 bins.
// After reset a clearing pass runs and no request is taken.
module rgb_luma_histogram_stats_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_func,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_blue,
    input  logic                           i_last_pixel,
    input  logic [7:0]                     i_bin_index,
    input  logic                           i_cfg_we,
    input  logic [rlh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [23:0]                    o_count_red,
    output logic [23:0]                    o_count_green,
    output logic [23:0]                    o_count_blue,
    output logic [23:0]                    o_count_luma,
    output logic [23:0]                    o_robust_peak,
    output logic                           o_shadow_clipped,
    output logic                           o_highlight_clipped,
    output logic [23:0]                    o_samples_taken
);
    import rlh_pkg::*;

    t_cmd    f_cmd, q_cmd;
    t_stat   stat;
    t_result res;
    logic    q_push, q_pop, q_full, q_empty;

    rlh_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_red, .i_green, .i_blue,
        .i_last_pixel, .i_bin_index, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_q_full(q_full), .i_stat(stat), .o_push(q_push), .o_cmd(f_cmd)
    );

    rlh_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_cmd(f_cmd), .i_pop(q_pop),
        .o_cmd(q_cmd), .o_full(q_full), .o_empty(q_empty)
    );

    rlh_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_cmd(q_cmd), .o_pop(q_pop),
        .o_stat(stat), .o_valid, .i_stall, .o_res(res)
    );

    assign o_kind              = res.kind;
    assign o_count_red         = res.count[0];
    assign o_count_green       = res.count[1];
    assign o_count_blue        = res.count[2];
    assign o_count_luma        = res.count[3];
    assign o_robust_peak       = res.peak;
    assign o_shadow_clipped    = res.shadow;
    assign o_highlight_clipped = res.highlight;
    assign o_samples_taken     = res.samples;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("queue overrun");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue underrun");

    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_SUMMARY) |->
        (o_count_red == '0 && o_count_green == '0 && o_count_blue == '0 &&
         o_count_luma == '0)) else $error("summary carries counts");

    a_empty_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_SUMMARY && o_samples_taken == '0) |->
        (o_robust_peak == '0 && !o_shadow_clipped && !o_highlight_clipped))
        else $error("summary without samples has peak or flags");

endmodule
